/* sv/color_matrix_4x5_apply_core_defines.svh */
// Assertion helpers for the color matrix RTL.
`ifndef COLOR_MATRIX_4X5_APPLY_CORE_DEFINES_SVH
`define COLOR_MATRIX_4X5_APPLY_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define CM45_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cm45 check failed (same cycle)");

// Next-cycle implication, checked out of reset.
`define CM45_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cm45 check failed (next cycle)");

`endif

/* sv/cm45_pkg.sv */
`timescale 1ns / 1ps
package cm45_pkg;

  localparam int CHAN_W  = 8;
  localparam int COEF_W  = 16;
  localparam int PROD_W  = 24;
  localparam int ACC_W   = 27;
  localparam int FRAC_W  = 12;
  localparam int NUM_CH  = 4;
  localparam int ROW_W   = 64;
  localparam int IDX_W   = 3;

  typedef logic [CHAN_W-1:0]              chan_t;
  typedef chan_t [NUM_CH-1:0]             pix_t;
  typedef logic [ROW_W-1:0]               row_t;
  typedef logic signed [COEF_W-1:0]       coef_t;
  typedef logic signed [PROD_W-1:0]       prod_t;
  typedef logic signed [ACC_W-1:0]        acc_t;
  typedef acc_t [NUM_CH-1:0]              acc_vec_t;

  typedef struct packed {
    logic en_mul;
    logic en_sum;
    logic en_out;
  } pipe_ctl_t;

  localparam logic [IDX_W-1:0] REG_ROW_BLUE  = 3'd0;
  localparam logic [IDX_W-1:0] REG_ROW_GREEN = 3'd1;
  localparam logic [IDX_W-1:0] REG_ROW_RED   = 3'd2;
  localparam logic [IDX_W-1:0] REG_ROW_ALPHA = 3'd3;
  localparam logic [IDX_W-1:0] REG_OFFSETS   = 3'd4;

  localparam row_t ROW_BLUE_RST  = 64'h0000_0000_0000_1000;
  localparam row_t ROW_GREEN_RST = 64'h0000_0000_1000_0000;
  localparam row_t ROW_RED_RST   = 64'h0000_1000_0000_0000;
  localparam row_t ROW_ALPHA_RST = 64'h1000_0000_0000_0000;
  localparam row_t OFFSETS_RST   = 64'h0000_0000_0000_0000;

  localparam logic [FRAC_W-1:0] ROUND_HALF = 12'h800;
  localparam chan_t             CHAN_MAX   = 8'hFF;

  // Round to nearest, ties to even, then clamp to 0..255.
  function automatic chan_t round_sat(acc_t acc);
    logic [ACC_W-FRAC_W-1:0] q;
    logic [FRAC_W-1:0]       rem;
    logic                    up;
    logic [ACC_W-FRAC_W:0]   qr;
    q   = acc[ACC_W-1:FRAC_W];
    rem = acc[FRAC_W-1:0];
    up  = (rem > ROUND_HALF) || ((rem == ROUND_HALF) && q[0]);
    qr  = {1'b0, q} + (ACC_W-FRAC_W+1)'(up);
    if (acc[ACC_W-1]) begin
      return '0;
    end else if (qr > (ACC_W-FRAC_W+1)'(CHAN_MAX)) begin
      return CHAN_MAX;
    end else begin
      return qr[CHAN_W-1:0];
    end
  endfunction

endpackage

/* sv/cm45_in_if.sv */
`timescale 1ns / 1ps
interface cm45_in_if;
  import cm45_pkg::*;
  logic  valid;
  logic  ready;
  chan_t in_blue;
  chan_t in_green;
  chan_t in_red;
  chan_t in_alpha;

  modport source (output valid, output in_blue, output in_green, output in_red,
                  output in_alpha, input ready);
  modport sink (input valid, input in_blue, input in_green, input in_red,
                input in_alpha, output ready);
endinterface

/* sv/cm45_out_if.sv */
`timescale 1ns / 1ps
interface cm45_out_if;
  import cm45_pkg::*;
  logic  valid;
  logic  ready;
  chan_t out_blue;
  chan_t out_green;
  chan_t out_red;
  chan_t out_alpha;

  modport source (output valid, output out_blue, output out_green, output out_red,
                  output out_alpha, input ready);
  modport sink (input valid, input out_blue, input out_green, input out_red,
                input out_alpha, output ready);
endinterface

/* sv/cm45_lane.sv */
`timescale 1ns / 1ps
module cm45_lane
  import cm45_pkg::*;
(
  input  logic      clk,
  input  pipe_ctl_t ctl,
  input  row_t      coefs,
  input  coef_t     offset,
  input  pix_t      pix,
  output acc_t      acc
);

  prod_t [NUM_CH-1:0] prod;
  coef_t              offset_q;
  acc_t               sum;

  // Stage 1: four coefficient x channel products.
  always_ff @(posedge clk) begin
    if (ctl.en_mul) begin
      for (int c = 0; c < NUM_CH; c++) begin
        prod[c] <= PROD_W'($signed(coefs[c*COEF_W +: COEF_W]) *
                           $signed({1'b0, pix[c]}));
      end
      offset_q <= offset;
    end
  end

  always_comb begin
    sum = ACC_W'($signed({offset_q, 8'h00}));
    for (int c = 0; c < NUM_CH; c++) begin
      sum = sum + ACC_W'(prod[c]);
    end
  end

  // Stage 2: accumulate with offset (12 fraction bits).
  always_ff @(posedge clk) begin
    if (ctl.en_sum) begin
      acc <= sum;
    end
  end

endmodule

/* sv/cm45_merge.sv */
`timescale 1ns / 1ps
module cm45_merge
  import cm45_pkg::*;
(
  input  logic      clk,
  input  pipe_ctl_t ctl,
  input  acc_vec_t  acc,
  output pix_t      pix
);

  always_ff @(posedge clk) begin
    if (ctl.en_out) begin
      for (int r = 0; r < NUM_CH; r++) begin
        pix[r] <= round_sat(acc[r]);
      end
    end
  end

endmodule

/* sv/color_matrix_4x5_apply_core.sv */
// Pipeline: multiply, sum and round registers lie between the input transaction and
// the output; output valid is registered alongside the round stage's result.
// Throughput: one pixel per cycle; each stage advances when the next one frees up.
// Four channel lanes run side by side; the merge stage rounds, clamps and registers.
// Reset (rst, synchronous, active high) empties the pipeline and restores identity
// coefficients with zero offsets.
`timescale 1ns / 1ps
`include "color_matrix_4x5_apply_core_defines.svh"
module color_matrix_4x5_apply_core
  import cm45_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [IDX_W-1:0] cfg_index,
  input  row_t             cfg_data,
  cm45_in_if.sink          pix_in,
  cm45_out_if.source       pix_out
);

  row_t [NUM_CH-1:0] row_coefs;
  row_t              offsets;
  logic              v_mul;
  logic              v_sum;
  logic              v_out;
  pipe_ctl_t         ctl;
  pix_t              pix;
  acc_vec_t          acc;
  pix_t              result;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_coefs[0] <= ROW_BLUE_RST;
      row_coefs[1] <= ROW_GREEN_RST;
      row_coefs[2] <= ROW_RED_RST;
      row_coefs[3] <= ROW_ALPHA_RST;
      offsets      <= OFFSETS_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_ROW_BLUE:  row_coefs[0] <= cfg_data;
        REG_ROW_GREEN: row_coefs[1] <= cfg_data;
        REG_ROW_RED:   row_coefs[2] <= cfg_data;
        REG_ROW_ALPHA: row_coefs[3] <= cfg_data;
        REG_OFFSETS:   offsets      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    ctl.en_out = !v_out || pix_out.ready;
    ctl.en_sum = !v_sum || ctl.en_out;
    ctl.en_mul = !v_mul || ctl.en_sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_mul <= 1'b0;
      v_sum <= 1'b0;
      v_out <= 1'b0;
    end else begin
      if (ctl.en_mul) v_mul <= pix_in.valid;
      if (ctl.en_sum) v_sum <= v_mul;
      if (ctl.en_out) v_out <= v_sum;
    end
  end

  assign pix_in.ready = ctl.en_mul;
  assign pix = {pix_in.in_alpha, pix_in.in_red, pix_in.in_green, pix_in.in_blue};

  for (genvar r = 0; r < NUM_CH; r++) begin : g_lane
    cm45_lane u_lane (
      .clk    (clk),
      .ctl    (ctl),
      .coefs  (row_coefs[r]),
      .offset (offsets[r*COEF_W +: COEF_W]),
      .pix    (pix),
      .acc    (acc[r])
    );
  end

  cm45_merge u_merge (
    .clk (clk),
    .ctl (ctl),
    .acc (acc),
    .pix (result)
  );

  assign pix_out.valid     = v_out;
  assign pix_out.out_blue  = result[0];
  assign pix_out.out_green = result[1];
  assign pix_out.out_red   = result[2];
  assign pix_out.out_alpha = result[3];

  `CM45_ASSERT_NEXT(a_accept_fills_mul, clk, rst, pix_in.valid && pix_in.ready, v_mul)
  `CM45_ASSERT_NEXT(a_mul_held, clk, rst, v_mul && !ctl.en_sum, v_mul)
  `CM45_ASSERT_NEXT(a_sum_to_out, clk, rst, v_sum && ctl.en_out, pix_out.valid)
  `CM45_ASSERT_NOW(a_ready_when_bubble, clk, rst, !v_mul || !v_sum || !v_out, pix_in.ready)

endmodule
